// ===== rtl/ack_pending_message_table_top_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pending message table
// Clocked assertion helpers that compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef ACK_PENDING_MESSAGE_TABLE_TOP_DEFINES_SVH
`define ACK_PENDING_MESSAGE_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define APMT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define APMT_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define APMT_ASSERT(label, clk, rst, prop, msg)
`define APMT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/apmt_pkg.sv =====
// ---------------------------------------------------------------------------
// apmt_pkg
// Types and constants shared by the pending message table files.
// ---------------------------------------------------------------------------
`default_nettype none
package apmt_pkg;
   localparam logic [2:0] MODE_ADD        = 3'd0;
   localparam logic [2:0] MODE_REMOVE     = 3'd1;
   localparam logic [2:0] MODE_TICK       = 3'd2;
   localparam logic [2:0] MODE_NOTIFY_ALL = 3'd3;
   localparam logic [2:0] MODE_REMOVE_ALL = 3'd4;
   localparam logic [2:0] MODE_TIMER_RST  = 3'd5;
   localparam logic [2:0] MODE_NEXT_ID    = 3'd6;

   localparam logic [1:0] EV_NEW     = 2'd0;
   localparam logic [1:0] EV_REMOVED = 2'd1;
   localparam logic [1:0] EV_EXPIRED = 2'd2;
   localparam logic [1:0] EV_DONE    = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [1:0] REG_LIMIT  = 2'd0;
   localparam logic [1:0] REG_PERIOD = 2'd1;
   localparam logic [1:0] REG_IDBASE = 2'd2;

   localparam int DATA_W = 32 + 8 + 32 + 8 + 32 + 17;

   typedef struct packed {
      logic [31:0] id;
      logic [7:0]  count;
      logic [31:0] flags;
      logic [7:0]  kind;
      logic [31:0] handle;
      logic [16:0] len_heap;
   } slot_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] out_id;
      logic [7:0]  out_count;
      logic [31:0] out_flags;
      logic [7:0]  out_kind;
      logic [31:0] out_handle;
      logic [15:0] out_len;
      logic        out_heap;
      logic [1:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/apmt_ram.sv =====
// ---------------------------------------------------------------------------
// apmt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module apmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                           clock,
   input  wire logic                                           we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                               wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                               rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

// ===== rtl/ack_pending_message_table_top.sv =====
// ---------------------------------------------------------------------------
// ack_pending_message_table_top
// Table of messages awaiting acknowledgement, kept in insertion order.
// ---------------------------------------------------------------------------
// channel | direction | handshake
// req     | in        | req_tvalid / req_tready
// rsp     | out       | rsp_tvalid / rsp_tready, rsp_tlast closes a run
// csr     | in        | APB write at psel & penable & pwrite
//
// Each list entry visited is a read of the slot RAM (S_RD) followed by an
// evaluation (S_EVAL) that may write the slot back or emit an event.
// Add searches the slots for a free one, starting from slot 0.
// Reset is synchronous; slot contents need no clearing, valid bits are flops.
// Each result waits in the output register until taken, stalling the walk.
`default_nettype none
`include "ack_pending_message_table_top_defines.svh"
module ack_pending_message_table_top #(
   parameter int DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mode, msg_id, ack_needed, msg_flags, msg_kind, buf_handle, buf_len,
   // heap_owned from bit 0 up, zero filled to 128 bits
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // event_kind, out_id, out_count, out_flags, out_kind, out_handle, out_len,
   // out_heap, status from bit 0 up, zero filled to 136 bits
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import apmt_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FIND = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_INC  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // Pass codes for the list walk.
   localparam logic [2:0] P_REMOVE = 3'd0;
   localparam logic [2:0] P_NOTIFY = 3'd1;
   localparam logic [2:0] P_CLEAR  = 3'd2;
   localparam logic [2:0] P_DROP   = 3'd3;
   localparam logic [2:0] P_BUMP   = 3'd4;

   logic [7:0]  limit_ff;
   logic [15:0] period_ff, idbase_ff;
   logic [DEPTH-1:0] valid_ff;
   logic [AW-1:0] order_ff [DEPTH];
   logic [LW-1:0] len_ff;
   logic          run_ff;
   logic [15:0]   cnt_ff, nid_ff;

   logic [2:0]    state_ff, ret_ff, pass_ff;
   logic [LW-1:0] pos_ff;
   logic [AW-1:0] slot_ff;
   slot_type      in_ff;
   logic          ack_ff;
   logic [1:0]    status_ff;
   logic [31:0]   gen_ff;
   logic          addsteps_ff;

   logic          ov_ff;
   rsp_type       od_ff;
   logic          ol_ff;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   slot_type      wdata, rdata;

   apmt_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata));

   wire cfg_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LIMIT:  csr_prdata = {24'd0, limit_ff};
         REG_PERIOD: csr_prdata = {16'd0, period_ff};
         REG_IDBASE: csr_prdata = {16'd0, idbase_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = ol_ff;
   assign rsp_tdata  = {3'd0, od_ff.status, od_ff.out_heap, od_ff.out_len, od_ff.out_handle,
                        od_ff.out_kind, od_ff.out_flags, od_ff.out_count, od_ff.out_id,
                        od_ff.event_kind};

   wire out_free = !ov_ff || rsp_tready;
   wire [AW-1:0] cur_slot = order_ff[pos_ff[AW-1:0]];
   wire [LW-1:0] len_m1 = len_ff - LW'(1);
   wire [15:0] per_eff = (period_ff == 16'd0) ? 16'd1 : period_ff;

   function automatic rsp_type mk(logic [1:0] k, slot_type s);
      rsp_type r;
      r.event_kind = k; r.out_id = s.id; r.out_count = s.count;
      r.out_flags = s.flags; r.out_kind = s.kind; r.out_handle = s.handle;
      r.out_len = s.len_heap[15:0]; r.out_heap = s.len_heap[16]; r.status = ST_OK;
      return r;
   endfunction

   slot_type bumped;
   always_comb begin
      bumped = rdata;
      if (rdata.count != 8'hFF) begin
         bumped.count = rdata.count + 8'd1;
      end
   end

   always_comb begin
      we = 1'b0; waddr = slot_ff; wdata = bumped; raddr = cur_slot;
      if (state_ff == S_FIND && !valid_ff[slot_ff]) begin
         we = 1'b1; wdata = in_ff; wdata.count = 8'd1;
      end else if (state_ff == S_EVAL && out_free &&
                   (pass_ff == P_NOTIFY || pass_ff == P_BUMP)) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 8'd3; period_ff <= 16'd60; idbase_ff <= 16'd1;
         valid_ff <= '0; len_ff <= '0; run_ff <= 1'b0; cnt_ff <= '0;
         nid_ff <= 16'd1; state_ff <= S_IDLE; ov_ff <= 1'b0;
      end else begin
         if (cfg_wr) begin
            unique case (csr_paddr[3:2])
               REG_LIMIT:  limit_ff <= csr_pwdata[7:0];
               REG_PERIOD: period_ff <= csr_pwdata[15:0];
               REG_IDBASE: idbase_ff <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (ov_ff && rsp_tready) begin
            ov_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               in_ff.id <= req_tdata[34:3];
               ack_ff <= req_tdata[35];
               in_ff.flags <= req_tdata[67:36];
               in_ff.kind <= req_tdata[75:68];
               in_ff.handle <= req_tdata[107:76];
               in_ff.len_heap <= req_tdata[124:108];
               in_ff.count <= 8'd0;
               status_ff <= ST_OK; gen_ff <= '0; pos_ff <= '0; slot_ff <= '0;
               addsteps_ff <= 1'b0; state_ff <= S_DONE;
               unique case (req_tdata[2:0])
                  MODE_ADD: begin
                     state_ff <= S_OUT; ret_ff <= S_FIND; addsteps_ff <= 1'b1;
                  end
                  MODE_REMOVE: begin
                     status_ff <= ST_NOT_FOUND; pass_ff <= P_REMOVE; state_ff <= S_RD;
                  end
                  MODE_TICK: if (run_ff) begin
                     if (cnt_ff <= 16'd1) begin
                        pass_ff <= P_DROP; state_ff <= S_RD;
                     end else begin
                        cnt_ff <= cnt_ff - 16'd1;
                     end
                  end
                  MODE_NOTIFY_ALL: begin
                     pass_ff <= P_NOTIFY; state_ff <= S_RD;
                  end
                  MODE_REMOVE_ALL: begin
                     pass_ff <= P_CLEAR; state_ff <= S_RD;
                  end
                  MODE_TIMER_RST: begin
                     run_ff <= 1'b0; cnt_ff <= '0;
                  end
                  MODE_NEXT_ID: begin
                     gen_ff <= {16'd0, (nid_ff == 16'hFFFF) ? idbase_ff : nid_ff};
                     nid_ff <= ((nid_ff == 16'hFFFF) ? idbase_ff : nid_ff) + 16'd1;
                  end
                  default: ;
               endcase
            end
            S_OUT: if (out_free) begin
               // Add entry: emit new or rejected event first as needed.
               ov_ff <= 1'b0;
               if (addsteps_ff) begin
                  addsteps_ff <= 1'b0;
                  if (!ack_ff) begin
                     ov_ff <= 1'b1; od_ff <= mk(EV_NEW, in_ff); ol_ff <= 1'b0;
                     state_ff <= S_INC; ret_ff <= S_DONE;
                  end else if (&valid_ff || len_ff >= LW'(DEPTH)) begin
                     ov_ff <= 1'b1; od_ff <= mk(EV_REMOVED, in_ff); ol_ff <= 1'b0;
                     status_ff <= ST_FULL; state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_FIND;
                  end
               end else begin
                  state_ff <= ret_ff;
               end
            end
            S_INC: if (out_free) begin
               ov_ff <= 1'b1; od_ff <= mk(EV_REMOVED, in_ff); ol_ff <= 1'b0;
               if (!run_ff && len_ff != '0) begin
                  run_ff <= 1'b1; cnt_ff <= per_eff;
               end
               state_ff <= S_DONE;
            end
            S_FIND: begin
               if (!valid_ff[slot_ff]) begin
                  if (out_free) begin
                     valid_ff[slot_ff] <= 1'b1;
                     order_ff[len_ff[AW-1:0]] <= slot_ff;
                     len_ff <= len_ff + LW'(1);
                     ov_ff <= 1'b1; od_ff <= mk(EV_NEW, wdata); ol_ff <= 1'b0;
                     if (!run_ff) begin
                        run_ff <= 1'b1; cnt_ff <= per_eff;
                     end
                     state_ff <= S_DONE;
                  end
               end else begin
                  slot_ff <= slot_ff + AW'(1);
               end
            end
            S_RD: begin
               if (pos_ff >= len_ff) begin
                  priority if (pass_ff == P_CLEAR) begin
                     len_ff <= '0; run_ff <= 1'b0; cnt_ff <= '0; state_ff <= S_DONE;
                  end else if (pass_ff == P_DROP) begin
                     pos_ff <= '0;
                     if (len_ff == '0) begin
                        run_ff <= 1'b0; cnt_ff <= '0; state_ff <= S_DONE;
                     end else begin
                        pass_ff <= P_BUMP;
                     end
                  end else if (pass_ff == P_BUMP) begin
                     run_ff <= 1'b1; cnt_ff <= per_eff; state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end else begin
                  slot_ff <= cur_slot; state_ff <= S_EVAL;
               end
            end
            S_EVAL: if (out_free) begin
               state_ff <= S_RD;
               unique case (pass_ff)
                  P_REMOVE: if (rdata.id == in_ff.id) begin
                     ov_ff <= 1'b1; od_ff <= mk(EV_REMOVED, rdata); ol_ff <= 1'b0;
                     valid_ff[slot_ff] <= 1'b0;
                     for (int i = 0; i < DEPTH - 1; i++) begin
                        if (LW'(i) >= pos_ff) order_ff[i] <= order_ff[i + 1];
                     end
                     len_ff <= len_m1; status_ff <= ST_OK;
                     if (len_m1 == '0) begin
                        run_ff <= 1'b0; cnt_ff <= '0;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     pos_ff <= pos_ff + LW'(1);
                  end
                  P_DROP: if (rdata.count >= limit_ff) begin
                     ov_ff <= 1'b1; od_ff <= mk(EV_REMOVED, rdata); ol_ff <= 1'b0;
                     valid_ff[slot_ff] <= 1'b0;
                     for (int i = 0; i < DEPTH - 1; i++) begin
                        if (LW'(i) >= pos_ff) order_ff[i] <= order_ff[i + 1];
                     end
                     len_ff <= len_m1;
                  end else begin
                     pos_ff <= pos_ff + LW'(1);
                  end
                  P_CLEAR: begin
                     ov_ff <= 1'b1; od_ff <= mk(EV_REMOVED, rdata); ol_ff <= 1'b0;
                     valid_ff[slot_ff] <= 1'b0; pos_ff <= pos_ff + LW'(1);
                  end
                  default: begin
                     ov_ff <= 1'b1; od_ff <= mk(EV_EXPIRED, bumped); ol_ff <= 1'b0;
                     pos_ff <= pos_ff + LW'(1);
                  end
               endcase
            end
            S_DONE: if (out_free) begin
               ov_ff <= 1'b1; ol_ff <= 1'b1;
               od_ff <= '{event_kind: EV_DONE, out_id: gen_ff, status: status_ff,
                          default: '0};
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `APMT_ASSERT(a_len_bound, clock, reset, len_ff <= LW'(DEPTH), "list length out of range")
   `APMT_ASSERT(a_run_nonempty, clock, reset, (state_ff == S_IDLE && run_ff) |-> len_ff != '0, "timer running on empty list")
   `APMT_ASSERT(a_hold, clock, reset, (ov_ff && !rsp_tready) |=> (ov_ff && $stable(od_ff)), "result dropped while stalled")
   `APMT_ASSERT(a_count_valid, clock, reset, $countones(valid_ff) == 32'(len_ff) || state_ff != S_IDLE, "valid bits disagree with list length")
endmodule
`default_nettype wire

// ===== dv/tb_ack_pending_message_table_top.sv =====
// ---------------------------------------------------------------------------
// Pending message table testbench
// Drives add, remove, tick and bulk operations with random gaps on both
// streams, predicts every event and completion item and compares them in order.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_ack_pending_message_table_top;
   timeunit 1ns;
   timeprecision 1ps;
   import apmt_pkg::*;

   localparam logic [2:0] MODE_UNUSED = 3'd7;

   typedef struct packed {
      logic        last;
      logic [1:0]  status;
      logic        heap;
      logic [15:0] len;
      logic [31:0] handle;
      logic [7:0]  kind;
      logic [31:0] flags;
      logic [7:0]  count;
      logic [31:0] id;
      logic [1:0]  ev;
   } table_event_type;

   typedef struct {
      logic [2:0]  mode;
      logic [31:0] id;
      logic        ack;
      logic [31:0] flags;
      logic [7:0]  kind;
      logic [31:0] handle;
      logic [15:0] len;
      logic        heap;
   } table_op_type;

   class table_scoreboard_type;
      logic [7:0]  limit;
      logic [15:0] period;
      logic [15:0] base;
      logic        used[16];
      logic [31:0] s_id[16];
      logic [7:0]  s_cnt[16];
      logic [31:0] s_flags[16];
      logic [7:0]  s_kind[16];
      logic [31:0] s_handle[16];
      logic [16:0] s_lh[16];
      int          order[16];
      int          length;
      logic        running;
      logic [15:0] countdown;
      logic [15:0] next_id;
      table_event_type pending_events[$];
      int          errors;

      function new();
         limit = 8'd3;
         period = 16'd60;
         base = 16'd1;
         foreach (used[i]) begin
            used[i] = 1'b0;
            s_cnt[i] = '0;
         end
         length = 0;
         running = 1'b0;
         countdown = '0;
         next_id = 16'd1;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] v);
         case (idx)
            REG_LIMIT: limit = v[7:0];
            REG_PERIOD: period = v[15:0];
            REG_IDBASE: base = v[15:0];
            default: ;
         endcase
      endfunction

      function void push(logic [1:0] ev, logic [31:0] id, logic [7:0] c, logic [31:0] f,
                         logic [7:0] k, logic [31:0] h, logic [16:0] lh);
         table_event_type e;
         e = '{1'b0, ST_OK, lh[16], lh[15:0], h, k, f, c, id, ev};
         pending_events.push_back(e);
      endfunction

      function void push_slot(logic [1:0] ev, int s);
         push(ev, s_id[s], s_cnt[s], s_flags[s], s_kind[s], s_handle[s], s_lh[s]);
      endfunction

      function void drop_at(int p);
         for (int i = p; i + 1 < length; i++) order[i] = order[i + 1];
         length--;
      endfunction

      function void note_op(table_op_type op);
         logic [1:0]  st;
         logic [31:0] gen;
         int          s;
         int          p;
         table_event_type e;
         st = ST_OK;
         gen = '0;
         case (op.mode)
            MODE_ADD: begin
               logic rej;
               rej = 1'b0;
               if (op.ack) begin
                  s = -1;
                  for (int i = 0; i < 16; i++) if (!used[i] && s < 0) s = i;
                  if (s < 0) begin
                     push(EV_REMOVED, op.id, 8'd0, op.flags, op.kind, op.handle,
                          {op.heap, op.len});
                     st = ST_FULL;
                     rej = 1'b1;
                  end else begin
                     used[s] = 1'b1;
                     s_id[s] = op.id;
                     s_cnt[s] = 8'd1;
                     s_flags[s] = op.flags;
                     s_kind[s] = op.kind;
                     s_handle[s] = op.handle;
                     s_lh[s] = {op.heap, op.len};
                     order[length] = s;
                     length++;
                     push_slot(EV_NEW, s);
                  end
               end else begin
                  push(EV_NEW, op.id, 8'd0, op.flags, op.kind, op.handle, {op.heap, op.len});
                  push(EV_REMOVED, op.id, 8'd0, op.flags, op.kind, op.handle,
                       {op.heap, op.len});
               end
               if (!rej && !running && length != 0) begin
                  running = 1'b1;
                  countdown = period;
               end
            end
            MODE_REMOVE: begin
               st = ST_NOT_FOUND;
               for (int i = 0; i < length; i++) begin
                  if (st == ST_NOT_FOUND && s_id[order[i]] == op.id) begin
                     s = order[i];
                     push_slot(EV_REMOVED, s);
                     used[s] = 1'b0;
                     s_cnt[s] = '0;
                     drop_at(i);
                     st = ST_OK;
                     break;
                  end
               end
               if (st == ST_OK && length == 0) begin
                  running = 1'b0;
                  countdown = '0;
               end
            end
            MODE_TICK: begin
               if (running) begin
                  if (countdown <= 16'd1) begin
                     p = 0;
                     while (p < length) begin
                        s = order[p];
                        if (s_cnt[s] >= limit) begin
                           push_slot(EV_REMOVED, s);
                           used[s] = 1'b0;
                           s_cnt[s] = '0;
                           drop_at(p);
                        end else p++;
                     end
                     if (length == 0) begin
                        running = 1'b0;
                        countdown = '0;
                     end else begin
                        for (int i = 0; i < length; i++) begin
                           s = order[i];
                           if (s_cnt[s] != 8'hFF) s_cnt[s]++;
                           push_slot(EV_EXPIRED, s);
                        end
                        countdown = period;
                     end
                  end else countdown--;
               end
            end
            MODE_NOTIFY_ALL: begin
               for (int i = 0; i < length; i++) begin
                  s = order[i];
                  if (s_cnt[s] != 8'hFF) s_cnt[s]++;
                  push_slot(EV_EXPIRED, s);
               end
            end
            MODE_REMOVE_ALL: begin
               for (int i = 0; i < length; i++) begin
                  s = order[i];
                  push_slot(EV_REMOVED, s);
                  used[s] = 1'b0;
                  s_cnt[s] = '0;
               end
               length = 0;
               running = 1'b0;
               countdown = '0;
            end
            MODE_TIMER_RST: begin
               running = 1'b0;
               countdown = '0;
            end
            MODE_NEXT_ID: begin
               if (next_id == 16'hFFFF) next_id = base;
               gen = {16'd0, next_id};
               next_id = next_id + 16'd1;
            end
            default: ;
         endcase
         e = '0;
         e.ev = EV_DONE;
         e.id = gen;
         e.status = st;
         e.last = 1'b1;
         pending_events.push_back(e);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         errors++;
      endfunction

      function void check_event(table_event_type got);
         table_event_type want;
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected item %h", $time, got);
            errors++;
            return;
         end
         want = pending_events.pop_front();
         if (got.ev !== want.ev) report("event_kind", want.ev, got.ev);
         if (got.id !== want.id) report("out_id", want.id, got.id);
         if (got.count !== want.count) report("out_count", want.count, got.count);
         if (got.flags !== want.flags) report("out_flags", want.flags, got.flags);
         if (got.kind !== want.kind) report("out_kind", want.kind, got.kind);
         if (got.handle !== want.handle) report("out_handle", want.handle, got.handle);
         if (got.len !== want.len) report("out_len", want.len, got.len);
         if (got.heap !== want.heap) report("out_heap", want.heap, got.heap);
         if (got.status !== want.status) report("status", want.status, got.status);
         if (got.last !== want.last) report("tlast", want.last, got.last);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   table_scoreboard_type tracker;
   logic            stim_done;

   ack_pending_message_table_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("FAIL ack_pending_message_table_top");
      $finish;
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      tracker.write_reg(idx, v);
   endtask

   task automatic send_op(table_op_type op);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {3'd0, op.heap, op.len, op.handle, op.kind, op.flags, op.ack, op.id,
                    op.mode};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      tracker.note_op(op);
   endtask

   task automatic send_mode(logic [2:0] m, logic [31:0] id, logic ack);
      table_op_type op;
      op.mode = m;
      op.id = id;
      op.ack = ack;
      op.flags = $urandom;
      op.kind = 8'($urandom);
      op.handle = $urandom;
      op.len = 16'($urandom);
      op.heap = 1'($urandom);
      send_op(op);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic random_ops(int n);
      logic [31:0] id;
      int          r;
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         id = $urandom_range(0, 7);
         if (r < 35) send_mode(MODE_ADD, id, $urandom_range(0, 5) != 0);
         else if (r < 50) send_mode(MODE_REMOVE, id, 1'($urandom));
         else if (r < 78) send_mode(MODE_TICK, $urandom, 1'($urandom));
         else if (r < 84) send_mode(MODE_NOTIFY_ALL, $urandom, 1'($urandom));
         else if (r < 88) send_mode(MODE_REMOVE_ALL, $urandom, 1'($urandom));
         else if (r < 92) send_mode(MODE_TIMER_RST, $urandom, 1'($urandom));
         else if (r < 98) send_mode(MODE_NEXT_ID, $urandom, 1'($urandom));
         else send_mode(MODE_UNUSED, $urandom, 1'($urandom));
      end
   endtask

   initial begin
      table_op_type op;
      tracker = new();
      stim_done = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      op = '{MODE_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
             16'hFFFF, 1'b1};
      send_op(op);
      op = '{MODE_ADD, 32'h0, 1'b1, 32'h0, 8'h0, 32'h0, 16'h0, 1'b0};
      send_op(op);
      send_mode(MODE_ADD, 32'd5, 1'b0);
      send_mode(MODE_REMOVE, 32'd77, 1'b0);
      send_mode(MODE_NOTIFY_ALL, 32'd0, 1'b0);
      send_mode(MODE_REMOVE, 32'h0, 1'b0);
      send_mode(MODE_TIMER_RST, 32'd0, 1'b0);
      send_mode(MODE_NEXT_ID, 32'd0, 1'b0);
      send_mode(MODE_UNUSED, 32'd0, 1'b0);
      for (int i = 0; i < 17; i++) send_mode(MODE_ADD, 32'(i), 1'b1);
      drain();
      send_mode(MODE_REMOVE_ALL, 32'd0, 1'b0);
      drain();

      csr_write(REG_LIMIT, 32'd1);
      csr_write(REG_PERIOD, 32'd1);
      csr_write(REG_IDBASE, 32'd65534);
      send_mode(MODE_ADD, 32'd3, 1'b1);
      send_mode(MODE_TICK, 32'd0, 1'b0);
      send_mode(MODE_TICK, 32'd0, 1'b0);
      for (int i = 0; i < 3; i++) send_mode(MODE_NEXT_ID, 32'd0, 1'b0);
      random_ops(60);
      drain();

      csr_write(REG_LIMIT, 32'd255);
      csr_write(REG_PERIOD, 32'd3);
      csr_write(REG_IDBASE, 32'd0);
      random_ops(60);
      drain();

      csr_write(REG_LIMIT, 32'd2);
      csr_write(REG_PERIOD, 32'd65535);
      random_ops(20);
      drain();
      csr_write(REG_PERIOD, 32'd2);
      csr_write(REG_LIMIT, 32'd0);
      random_ops(60);
      drain();
      stim_done = 1'b1;
   end

   initial begin
      int wait_cycles;
      table_event_type got;
      rsp_tready = 1'b0;
      @(negedge reset);
      rsp_tready <= 1'b1;
      forever begin
         wait_cycles = $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) wait_cycles = 0;
         if (wait_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tlast, rsp_tdata[132:0]};
         tracker.check_event(got);
      end
   end

   initial begin
      wait (stim_done === 1'b1);
      @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_events.size() == 0) begin
         $display("PASS ack_pending_message_table_top");
      end else begin
         $display("FAIL ack_pending_message_table_top");
      end
      $finish;
   end
endmodule
`default_nettype wire
